### hdl/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types, register indexes and the record size lookup for the tagged
// record deframer.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int NUM_IDS   = 32;
  localparam int SIZE_REGS = 4;
  localparam int IDS_PER_REG = 8;

  // configuration register indexes
  localparam logic [2:0] REG_PRESENT     = 3'd0;
  localparam logic [2:0] REG_SIZES_0_7   = 3'd1;
  localparam logic [2:0] REG_SIZES_8_15  = 3'd2;
  localparam logic [2:0] REG_SIZES_16_23 = 3'd3;
  localparam logic [2:0] REG_SIZES_24_31 = 3'd4;

  // record id that terminates parsing of a frame
  localparam logic [15:0] ID_END = 16'hFFFF;

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_HDR_HIGH,
    RX_PAYLOAD
  } rx_phase_t;

  typedef enum logic [1:0] {
    PP_ID_LOW,
    PP_ID_HIGH,
    PP_DATA,
    PP_STOP
  } parse_phase_t;

  typedef struct packed {
    logic [NUM_IDS-1:0]         present;
    logic [SIZE_REGS-1:0][63:0] sizes;
  } cfg_t;

  typedef struct packed {
    logic [4:0] id;
    logic [7:0] offset;
    logic [7:0] data;
    logic       last;
  } rec_t;

  // byte k of sizes register r holds the size of id 8*r+k
  function automatic logic [7:0] size_of(input cfg_t cfg, input logic [4:0] id);
    logic [63:0] word;
    word = cfg.sizes[id[4:3]];
    return word[id[2:0]*8 +: 8];
  endfunction

endpackage

### hdl/trd_cfg.sv
// ----------------------------------------------------------------------------
// trd_cfg
// Configuration register file: present mask and per-id record sizes.
// ----------------------------------------------------------------------------
module trd_cfg import trd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output cfg_t        cfg
);

  logic [NUM_IDS-1:0]         present_mask;
  logic [SIZE_REGS-1:0][63:0] record_sizes;

  always_ff @(posedge clk) begin
    if (rst) begin
      present_mask <= '0;
      record_sizes <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRESENT:     present_mask    <= cfg_data[NUM_IDS-1:0];
        REG_SIZES_0_7:   record_sizes[0] <= cfg_data;
        REG_SIZES_8_15:  record_sizes[1] <= cfg_data;
        REG_SIZES_16_23: record_sizes[2] <= cfg_data;
        REG_SIZES_24_31: record_sizes[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.present = present_mask;
  assign cfg.sizes   = record_sizes;

endmodule

### hdl/trd_parse.sv
// ----------------------------------------------------------------------------
// trd_parse
// Per-byte receive and record parse state; produces at most one record byte
// for every accepted input byte.
// ----------------------------------------------------------------------------
module trd_parse import trd_pkg::*; #(
  parameter int CHUNK_BYTES = 64,
  parameter int FRAME_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       chunk_start,
  input  cfg_t       cfg,
  output logic       res_valid,
  output rec_t       res
);

  localparam int CP_W = $clog2(CHUNK_BYTES + 1);
  localparam int FL_W = $clog2(FRAME_BYTES + 1);
  localparam int CW   = (FL_W > 8) ? FL_W : 8;

  logic [FL_W-1:0] frame_length,     frame_length_next;
  logic [FL_W-1:0] received_count,   received_count_next;
  logic [CP_W-1:0] chunk_position,   chunk_position_next;
  rx_phase_t       receive_phase,    receive_phase_next;
  logic [7:0]      header_low,       header_low_next;
  parse_phase_t    parse_phase,      parse_phase_next;
  logic [7:0]      id_low,           id_low_next;
  logic [4:0]      current_id,       current_id_next;
  logic [7:0]      record_remaining, record_remaining_next;
  logic [7:0]      record_position,  record_position_next;

  logic            active;
  logic [15:0]     raw;
  logic [FL_W-1:0] count_inc;
  logic [FL_W-1:0] left;
  logic [7:0]      size;
  logic [7:0]      rem_dec;

  assign active    = chunk_start || (chunk_position < CP_W'(CHUNK_BYTES));
  assign count_inc = received_count + FL_W'(1);
  assign left      = frame_length - count_inc;
  // the id's low bits sit in the stored low byte while the high byte arrives
  assign size      = size_of(cfg, id_low[4:0]);
  assign rem_dec   = record_remaining - 8'd1;

  always_comb begin
    frame_length_next     = frame_length;
    received_count_next   = received_count;
    chunk_position_next   = chunk_position;
    receive_phase_next    = receive_phase;
    header_low_next       = header_low;
    parse_phase_next      = parse_phase;
    id_low_next           = id_low;
    current_id_next       = current_id;
    record_remaining_next = record_remaining;
    record_position_next  = record_position;
    res_valid             = 1'b0;
    res.id                = current_id;
    res.offset            = record_position;
    res.data              = data_byte;
    res.last              = (rem_dec == 8'd0);
    raw                   = 16'd0;

    if (active) begin
      chunk_position_next = chunk_start ? CP_W'(1) : chunk_position + CP_W'(1);

      if (receive_phase != RX_PAYLOAD) begin
        raw = {data_byte, header_low};
        if (chunk_start) begin
          header_low_next    = data_byte;
          receive_phase_next = RX_HDR_HIGH;
        end else if (receive_phase == RX_HDR_HIGH) begin
          receive_phase_next = RX_IDLE;
          if (raw != 16'd0 && raw <= 16'(FRAME_BYTES)) begin
            frame_length_next   = raw[FL_W-1:0];
            received_count_next = '0;
            parse_phase_next    = PP_ID_LOW;
            receive_phase_next  = RX_PAYLOAD;
          end else begin
            frame_length_next = '0;
          end
        end
      end else begin
        received_count_next = count_inc;
        raw = {data_byte, id_low};
        case (parse_phase)
          PP_ID_LOW: begin
            id_low_next      = data_byte;
            parse_phase_next = PP_ID_HIGH;
          end
          PP_ID_HIGH: begin
            if (raw == ID_END) begin
              parse_phase_next = PP_STOP;
            end else if (raw[15:5] == 11'd0 && cfg.present[raw[4:0]]) begin
              if (CW'(size) > CW'(left)) begin
                parse_phase_next = PP_STOP;
              end else if (size == 8'd0) begin
                parse_phase_next = PP_ID_LOW;
              end else begin
                current_id_next       = raw[4:0];
                record_remaining_next = size;
                record_position_next  = 8'd0;
                parse_phase_next      = PP_DATA;
              end
            end else begin
              parse_phase_next = PP_ID_LOW;
            end
          end
          PP_DATA: begin
            res_valid             = 1'b1;
            record_remaining_next = rem_dec;
            record_position_next  = record_position + 8'd1;
            if (rem_dec == 8'd0) parse_phase_next = PP_ID_LOW;
          end
          default: ;
        endcase
        // frame complete: back to waiting for a header
        if (count_inc >= frame_length) begin
          frame_length_next   = '0;
          received_count_next = '0;
          parse_phase_next    = PP_ID_LOW;
          receive_phase_next  = RX_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length     <= '0;
      received_count   <= '0;
      chunk_position   <= '0;
      receive_phase    <= RX_IDLE;
      header_low       <= '0;
      parse_phase      <= PP_ID_LOW;
      id_low           <= '0;
      current_id       <= '0;
      record_remaining <= '0;
      record_position  <= '0;
    end else if (accept) begin
      frame_length     <= frame_length_next;
      received_count   <= received_count_next;
      chunk_position   <= chunk_position_next;
      receive_phase    <= receive_phase_next;
      header_low       <= header_low_next;
      parse_phase      <= parse_phase_next;
      id_low           <= id_low_next;
      current_id       <= current_id_next;
      record_remaining <= record_remaining_next;
      record_position  <= record_position_next;
    end
  end

  // parsing only leaves the id-low phase inside a frame
  a_parse_in_frame: assert property (@(posedge clk) disable iff (rst)
    parse_phase != PP_ID_LOW |-> receive_phase == RX_PAYLOAD)
    else $error("parse phase active outside a frame");

  // a frame in progress always has bytes left to receive
  a_frame_left: assert property (@(posedge clk) disable iff (rst)
    receive_phase == RX_PAYLOAD |-> (frame_length != '0 && received_count < frame_length))
    else $error("frame count out of range");

  // a record being streamed always has bytes left
  a_record_left: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PP_DATA |-> record_remaining != 8'd0)
    else $error("record streaming with nothing remaining");

endmodule

### hdl/trd_outq.sv
// ----------------------------------------------------------------------------
// trd_outq
// Result register with a skid stage so the input side keeps moving while a
// record byte waits for the consumer.
// ----------------------------------------------------------------------------
module trd_outq import trd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  output logic push_ready,
  output logic out_valid,
  input  logic out_ready,
  output rec_t out_rec
);

  logic skid_valid;
  rec_t skid_rec;

  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_rec    <= skid_rec;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) out_rec <= push_rec;
      end
    end else if (push) begin
      skid_rec   <= push_rec;
      skid_valid <= 1'b1;
    end
  end

  // the skid stage only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds data while output is empty");

  // no push may arrive while the skid stage is full
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("push into full output queue");

endmodule

### hdl/tagged_record_deframer.sv
// ----------------------------------------------------------------------------
// tagged_record_deframer
// Deframes length-prefixed frames from fixed-size transfers and streams out
// the bytes of configured, present records tagged with id and offset.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                        | Dir
//  --------+------------------------------------------------+-----
//  in      | in_valid, in_ready, data_byte, chunk_start     | in
//  out     | out_valid, out_ready, record_id, record_offset,| out
//          | record_byte, record_last                       |
//  cfg     | cfg_we, cfg_index, cfg_data                    | in
//
//  One byte per cycle while in_ready is high: each accepted byte updates the
//  receive/parse state in the same cycle and its record byte (if any) lands in
//  the result register.
//  A skid stage behind the result register lets one more byte in while the
//  consumer stalls; in_ready drops only when both stages hold data.
//  Synchronous active-high reset clears state and configuration to zero.
//
module tagged_record_deframer import trd_pkg::*; #(
  parameter int CHUNK_BYTES = 64,
  parameter int FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        chunk_start,
  // record byte stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  record_id,
  output logic [7:0]  record_offset,
  output logic [7:0]  record_byte,
  output logic        record_last,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t cfg;
  logic accept;
  logic res_valid;
  rec_t res;
  rec_t out_rec;

  // an input transfer completes on valid and ready together
  assign accept = in_valid && in_ready;

  trd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // header, frame counting and record parse for the current byte
  trd_parse #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .chunk_start (chunk_start),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register plus skid stage
  trd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && res_valid),
    .push_rec   (res),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_rec    (out_rec)
  );

  assign record_id     = out_rec.id;
  assign record_offset = out_rec.offset;
  assign record_byte   = out_rec.data;
  assign record_last   = out_rec.last;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - tagged record deframer regression
// Drives framed byte transfers through the deframer, predicts the record
// byte stream with an in-bench model of the receive and parse state, and
// checks every output transfer in order, across several register settings
// and backpressure profiles.
// ----------------------------------------------------------------------------
module tb_top import trd_pkg::*; ();

  localparam int CHUNK      = 64;
  localparam int FRAME      = 256;
  localparam int SETTLE     = 8;       // result register + skid stage, with margin
  localparam int LONG_HOLD  = 300;     // receiver hold-off in the pressure phase
  localparam int CYCLE_CAP  = 200000;
  localparam int PH_PRESSURE = 1;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } rx_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        chunk_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  record_id;
  logic [7:0]  record_offset;
  logic [7:0]  record_byte;
  logic        record_last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [63:0] cfg_data = 64'd0;

  tagged_record_deframer #(
    .CHUNK_BYTES (CHUNK),
    .FRAME_BYTES (FRAME)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .chunk_start   (chunk_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_id     (record_id),
    .record_offset (record_offset),
    .record_byte   (record_byte),
    .record_last   (record_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  rx_byte_t byte_q[$];           // bytes waiting to be offered
  rec_t     pending_records[$];  // predicted record bytes, oldest first

  int unsigned bytes_queued    = 0;
  int unsigned bytes_sent      = 0;
  int unsigned records_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned cycles          = 0;
  int          send_idle_pct   = 0;
  int          recv_stall_pct  = 0;
  int          phase_id        = 0;
  int          hold_left       = 0;
  bit          hold_used       = 1'b0;

  // shadow of the configuration registers
  logic [31:0] present_m = '0;
  logic [63:0] sizes_m [SIZE_REGS] = '{default: '0};

  // shadow of the receive / parse state
  rx_phase_t    rx_st     = RX_IDLE;
  parse_phase_t pp_st     = PP_ID_LOW;
  logic [8:0]   frame_len = '0;
  logic [8:0]   rcvd      = '0;
  logic [6:0]   chunk_pos = '0;
  logic [7:0]   hdr_lo    = '0;
  logic [7:0]   id_lo     = '0;
  logic [4:0]   cur_id    = '0;
  logic [7:0]   rec_left  = '0;
  logic [7:0]   rec_pos   = '0;

  rec_t     drv_rec;
  rx_byte_t drv_item;
  rec_t     mon_rec;

  // --------------------------------------------------------------------------
  // Deframer model: advance the shadow state by one accepted byte; returns 1
  // and fills rec when the byte is streamed out as record data.
  // --------------------------------------------------------------------------
  function automatic bit deframe_byte(input logic [7:0] b, input logic st,
                                      output rec_t rec);
    logic [15:0] raw;
    logic [8:0]  room;
    logic [7:0]  sz;
    bit          hit;
    hit = 1'b0;
    rec = '0;
    if (st)
      chunk_pos = '0;
    else if (chunk_pos >= 7'(CHUNK))
      return 1'b0;                         // past the end of the transfer

    if (rx_st != RX_PAYLOAD) begin
      if (st) begin
        hdr_lo = b;                        // header (re)starts on any start byte
        rx_st  = RX_HDR_HIGH;
      end else if (rx_st == RX_HDR_HIGH) begin
        raw   = {b, hdr_lo};
        rx_st = RX_IDLE;
        if (!raw[15] && raw != 16'd0 && raw <= 16'(FRAME)) begin
          frame_len = raw[8:0];
          rcvd      = '0;
          pp_st     = PP_ID_LOW;
          rx_st     = RX_PAYLOAD;
        end else begin
          frame_len = '0;                  // empty or bad length: drop transfer
        end
      end
    end else begin
      rcvd = rcvd + 9'd1;
      room = frame_len - rcvd;
      case (pp_st)
        PP_ID_LOW: begin
          id_lo = b;
          pp_st = PP_ID_HIGH;
        end
        PP_ID_HIGH: begin
          raw = {b, id_lo};
          if (raw == ID_END) begin
            pp_st = PP_STOP;
          end else if (raw < 16'(NUM_IDS) && present_m[raw[4:0]]) begin
            sz = sizes_m[raw[4:3]][raw[2:0]*8 +: 8];
            if ({1'b0, sz} > room) begin
              pp_st = PP_STOP;             // record would run past frame end
            end else if (sz == 8'd0) begin
              pp_st = PP_ID_LOW;
            end else begin
              cur_id   = raw[4:0];
              rec_left = sz;
              rec_pos  = '0;
              pp_st    = PP_DATA;
            end
          end else begin
            pp_st = PP_ID_LOW;
          end
        end
        PP_DATA: begin
          rec_left   = rec_left - 8'd1;
          rec.id     = cur_id;
          rec.offset = rec_pos;
          rec.data   = b;
          rec.last   = (rec_left == 8'd0);
          hit        = 1'b1;
          rec_pos    = rec_pos + 8'd1;
          if (rec_left == 8'd0)
            pp_st = PP_ID_LOW;
        end
        default: ;                         // stopped: swallow rest of frame
      endcase
      if (rcvd >= frame_len) begin
        frame_len = '0;
        rcvd      = '0;
        pp_st     = PP_ID_LOW;
        rx_st     = RX_IDLE;
      end
    end

    if (chunk_pos < 7'(CHUNK))
      chunk_pos = chunk_pos + 7'd1;
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] d, input logic s);
    rx_byte_t it;
    it.data  = d;
    it.start = s;
    byte_q.push_back(it);
    bytes_queued++;
  endtask

  function automatic int rand_frame_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) return $urandom_range(1, 40);
    if (k < 95) return $urandom_range(41, 120);
    return $urandom_range(121, FRAME);
  endfunction

  // One well-formed frame: header, records filled from the current shadow
  // config (cut at the frame end), split over full transfers, then filler.
  // With overlong set the last transfer runs past CHUNK bytes.
  task automatic push_frame(input int flen, input bit overlong);
    logic [7:0]  pl[$];
    logic [15:0] rid;
    logic [15:0] len16;
    int          k, n, pos;
    while (pl.size() < flen) begin
      k = $urandom_range(0, 99);
      if (k < 72)      rid = 16'($urandom_range(0, NUM_IDS - 1));
      else if (k < 84) rid = 16'($urandom_range(NUM_IDS, NUM_IDS + 8));
      else if (k < 96) rid = 16'($urandom);
      else             rid = ID_END;
      pl.push_back(rid[7:0]);
      pl.push_back(rid[15:8]);
      n = 0;
      if (rid < 16'(NUM_IDS) && present_m[rid[4:0]])
        n = int'(sizes_m[rid[4:3]][rid[2:0]*8 +: 8]);
      repeat (n) pl.push_back(8'($urandom));
    end
    len16 = 16'(flen);
    push_byte(len16[7:0], 1'b1);
    push_byte(len16[15:8], 1'b0);
    pos = 2;
    for (int i = 0; i < flen; i++) begin
      if (pos == CHUNK) begin
        push_byte(pl[i], 1'b1);            // frame continues in next transfer
        pos = 1;
      end else begin
        push_byte(pl[i], 1'b0);
        pos++;
      end
    end
    n = overlong ? (CHUNK - pos + $urandom_range(1, 8)) : $urandom_range(0, 4);
    repeat (n) push_byte(8'($urandom), 1'b0);
  endtask

  // Noise and broken sequences
  task automatic push_noise();
    logic [15:0] bad;
    int          k, n;
    k = $urandom_range(0, 3);
    case (k)
      0: begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end
      1: begin
        if ($urandom_range(0, 1))
          bad = 16'h8000 | 16'($urandom);
        else
          bad = 16'($urandom_range(FRAME + 1, 32767));
        push_byte(bad[7:0], 1'b1);
        push_byte(bad[15:8], 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) push_byte(8'($urandom), 1'b0);
      end
      2: begin
        push_byte(8'd0, 1'b1);             // zero length
        push_byte(8'd0, 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) push_byte(8'($urandom), 1'b0);
      end
      default: begin
        push_byte(8'($urandom), 1'b1);     // header restarted by next start byte
        push_frame(rand_frame_len(), 1'b0);
      end
    endcase
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_PRESENT)
      present_m = val[31:0];
    else
      sizes_m[2'(idx - REG_SIZES_0_7)] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_sizes(input int top, input bit wild);
    logic [63:0] v;
    int          k;
    for (int i = 0; i < IDS_PER_REG; i++) begin
      if (wild) begin
        k = $urandom_range(0, 4);
        case (k)
          0:       v[i*8 +: 8] = 8'd0;
          1:       v[i*8 +: 8] = 8'd1;
          2:       v[i*8 +: 8] = 8'd254;
          3:       v[i*8 +: 8] = 8'd255;
          default: v[i*8 +: 8] = 8'($urandom);
        endcase
      end else begin
        v[i*8 +: 8] = 8'($urandom_range(0, top));
      end
    end
    return v;
  endfunction

  task automatic set_config(input logic [31:0] mask, input int top, input bit wild);
    write_reg(REG_PRESENT, {32'($urandom), mask});   // upper bits unused
    write_reg(REG_SIZES_0_7,   rand_sizes(top, wild));
    write_reg(REG_SIZES_8_15,  rand_sizes(top, wild));
    write_reg(REG_SIZES_16_23, rand_sizes(top, wild));
    write_reg(REG_SIZES_24_31, rand_sizes(top, wild));
  endtask

  // Hold the sender until every queued byte is taken and every predicted
  // record byte has come out, then let the pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    while (bytes_sent != bytes_queued || pending_records.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(input int id, input int send_pct, input int recv_pct,
                           input int budget);
    int unsigned base;
    @(negedge clk);
    phase_id       = id;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    base = bytes_queued;
    while (bytes_queued - base < budget) begin
      if ($urandom_range(0, 99) < 80)
        push_frame(rand_frame_len(), $urandom_range(0, 19) == 0);
      else
        push_noise();
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed frames, then randomized phases
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: ids 0/1/2 sized 1/2/0, id 31 sized 3, all present
    write_reg(REG_PRESENT,     64'h0000_0000_FFFF_FFFF);
    write_reg(REG_SIZES_0_7,   64'h0404_0404_0400_0201);
    write_reg(REG_SIZES_8_15,  64'h0404_0404_0404_0404);
    write_reg(REG_SIZES_16_23, 64'h0404_0404_0404_0404);
    write_reg(REG_SIZES_24_31, 64'h0304_0404_0404_0404);
    @(negedge clk);
    // frame of 13: id0 + 00, id31 + FF 80 7F, id2 (size 0), end id, one
    // byte after the end id that is swallowed
    push_byte(8'h0D, 1'b1); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h1F, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h7F, 1'b0);
    push_byte(8'h02, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    // negative length, then length just over the frame limit
    push_byte(8'hFF, 1'b1); push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b1); push_byte(8'h01, 1'b0);
    // zero length with a trailing byte in the same transfer
    push_byte(8'h00, 1'b1); push_byte(8'h00, 1'b0); push_byte(8'hAB, 1'b0);
    // header restart, length 3: unknown id 0x0100 then a lone trailing byte
    push_byte(8'h07, 1'b1); push_byte(8'h03, 1'b1); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'hCC, 1'b0);
    wait_drained();

    // pressure: sender never idles, receiver does one long hold-off (LONG_HOLD)
    set_config(32'hFFFF_FFFF, 12, 1'b0);
    run_phase(PH_PRESSURE, 0, 0, 200);

    set_config(32'($urandom), 20, 1'b0);
    run_phase(2, 56, 0, 200);

    set_config(32'($urandom), 8, 1'b0);
    run_phase(3, 0, 56, 200);

    set_config(32'($urandom), 0, 1'b1);
    run_phase(4, 9, 9, 180);

    // extremes: nothing present with maximal sizes, then all present sized 0
    write_reg(REG_PRESENT, 64'd0);
    for (int r = 0; r < SIZE_REGS; r++)
      write_reg(3'(REG_SIZES_0_7 + r), 64'hFFFF_FFFF_FFFF_FFFF);
    run_phase(5, 9, 9, 60);

    set_config(32'hFFFF_FFFF, 0, 1'b0);
    run_phase(6, 0, 0, 60);

    $display("Sent %0d bytes over 7 phases, checked %0d record bytes, %0d mismatches",
             bytes_sent, records_checked, mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: predict on each accepted transfer, then offer the next byte
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (deframe_byte(data_byte, chunk_start, drv_rec))
          pending_records.push_back(drv_rec);
        bytes_sent++;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_item     = byte_q.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= drv_item.data;
          chunk_start <= drv_item.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, during the pressure phase
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (phase_id == PH_PRESSURE && !hold_used && bytes_sent > 40) begin
      hold_left <= LONG_HOLD;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each output transfer with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_records.size() == 0) begin
          $error("record_id: expected none, got %0d (unexpected transfer)", record_id);
          mismatches++;
        end else begin
          mon_rec = pending_records.pop_front();
          check_field("record_id",     32'(mon_rec.id),     32'(record_id));
          check_field("record_offset", 32'(mon_rec.offset), 32'(record_offset));
          check_field("record_byte",   32'(mon_rec.data),   32'(record_byte));
          check_field("record_last",   32'(mon_rec.last),   32'(record_last));
          records_checked++;
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
